// ----- hdl/bitmap_first_fit_block_allocator_unit_assert.svh -----
// assertion helpers used by the checker file
`ifndef BITMAP_FIRST_FIT_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define BITMAP_FIRST_FIT_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication, sampled on aclk, off while aresetn is low
`define BFFA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off while aresetn is low
`define BFFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/bffa_pkg.sv -----
`default_nettype none
package bffa_pkg;

    // heap geometry, block size is a power of two
    localparam int NUM_BLOCKS  = 512;
    localparam int BLOCK_BYTES = 32768;

    localparam int BLK_W       = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W       = $clog2(NUM_BLOCKS + 1);
    localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);

    // fixed field widths of the result beat
    localparam int BYTES_W     = 25;
    localparam int USED_W      = 10;

    localparam logic [32:0] HEAP_BYTES =
        33'(longint'(NUM_BLOCKS) * longint'(BLOCK_BYTES));

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STS_ALLOC   = 2'd0,
        STS_FAIL    = 2'd1,
        STS_FREED   = 2'd2,
        STS_IGNORED = 2'd3
    } status_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] size_bytes;
        logic [31:0] address;
    } req_t;

    typedef struct packed {
        status_t             status;
        logic [31:0]         alloc_address;
        logic [BYTES_W-1:0]  used_bytes;
        logic [BYTES_W-1:0]  free_bytes;
        logic [USED_W-1:0]   used_blocks;
        logic [31:0]         live_allocs;
        logic [31:0]         allocs_total;
        logic [31:0]         frees_total;
    } rsp_t;

    // controls from the sequencer to the bitmap ring
    typedef struct packed {
        logic shift;
        logic head_bit;
    } ring_ctrl_t;

endpackage
`default_nettype wire

// ----- hdl/bffa_cell.sv -----
`default_nettype none
module bffa_cell
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic shift,
    input  wire logic d,
    output logic      q
);

    logic used_reg;

    // one bitmap bit, handed on to the neighbor while the ring turns
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= 1'b0;
        end else if (shift) begin
            used_reg <= d;
        end
    end

    assign q = used_reg;

endmodule
`default_nettype wire

// ----- hdl/bffa_chain.sv -----
`default_nettype none
module bffa_chain
    import bffa_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire ring_ctrl_t ctrl,
    output logic            head_out
);

    logic cell_q [NUM_BLOCKS];

    // cell 0 holds the block under the head; the head writes back into the far end
    for (genvar i = 0; i < NUM_BLOCKS; i++) begin : g_cell
        logic d;
        if (i == NUM_BLOCKS - 1) begin : g_tail
            assign d = ctrl.head_bit;
        end else begin : g_mid
            assign d = cell_q[i+1];
        end
        bffa_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .shift   (ctrl.shift),
            .d       (d),
            .q       (cell_q[i])
        );
    end

    assign head_out = cell_q[0];

endmodule
`default_nettype wire

// ----- hdl/bitmap_first_fit_block_allocator_unit.sv -----
`default_nettype none
// channel   dir  handshake             beat
// s_        in   s_valid / s_ready     req_t: kind, size_bytes, address
// m_        out  m_valid / m_ready     rsp_t: status, address, occupancy, counters
// cfg_      in   cfg_valid / cfg_ready pool base address, 32 bits
//
// the bitmap is a ring of NUM_BLOCKS one-bit cells turning one block per cycle
// past a head; one request is worked at a time, s_ready is high only when idle
// allocate that fits: scan turn, mark turn, result; allocate that finds no room:
// scan turn, result; zero or oversize size: result only
// free in range: free turn, result; free of zero or out of range: result only
// reset clears every cell at once; a held result beat only holds the result
// step, a new request is accepted while that beat waits
module bitmap_first_fit_block_allocator_unit
    import bffa_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire req_t        s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output rsp_t             m_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_MARK = 5'b00100,
        S_FREE = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t            state_reg;
    logic [31:0]       base_addr_reg;
    logic [BLK_W-1:0]  pos_reg;
    logic [CNT_W-1:0]  run_reg;
    logic [CNT_W-1:0]  need_reg;
    logic              found_reg;
    logic [BLK_W-1:0]  start_reg;
    logic [CNT_W-1:0]  end_reg;
    logic [BLK_W-1:0]  idx_reg;
    logic              freed_reg;
    status_t           status_reg;
    logic [CNT_W-1:0]  used_reg;
    logic [31:0]       live_reg;
    logic [31:0]       allocs_reg;
    logic [31:0]       frees_reg;
    logic              m_valid_reg;
    rsp_t              m_data_reg;

    logic [CNT_W-1:0]  used_next;
    logic [31:0]       live_next;
    logic [31:0]       allocs_next;
    logic [31:0]       frees_next;

    ring_ctrl_t        ring_ctrl;
    logic              head;

    // ---- request decode at accept ----
    logic [32:0]       need_full;
    logic              alloc_reject;
    logic [32:0]       offset;
    logic              free_reject;
    logic              accept;

    assign accept    = s_valid && s_ready;
    // round up to whole blocks without wraparound
    assign need_full = 33'(s_data.size_bytes >> BLOCK_SHIFT)
                     + 33'((s_data.size_bytes & 32'(BLOCK_BYTES - 1)) != 32'd0);
    assign alloc_reject = (s_data.size_bytes == 32'd0) || (need_full > 33'(NUM_BLOCKS));
    // borrow in bit 32 means the address sits below the heap
    assign offset      = {1'b0, s_data.address} - {1'b0, base_addr_reg};
    assign free_reject = (s_data.address == 32'd0) || offset[32] || (offset >= HEAP_BYTES);

    // ---- head of the ring ----
    logic              last;
    logic [CNT_W-1:0]  run_inc;
    logic [CNT_W-1:0]  pos_ext;
    logic [CNT_W-1:0]  start_full;
    logic              hit;
    logic              in_run;
    logic              free_hit;

    assign pos_ext    = CNT_W'(pos_reg);
    assign last       = (pos_reg == BLK_W'(NUM_BLOCKS - 1));
    assign run_inc    = run_reg + CNT_W'(1);
    // first window of need free blocks ends at this position
    assign hit        = (state_reg == S_SCAN) && !found_reg && !head && (run_inc == need_reg);
    assign start_full = pos_ext + CNT_W'(1) - need_reg;
    assign in_run     = (pos_ext >= CNT_W'(start_reg)) && (pos_ext < end_reg);
    assign free_hit   = (state_reg == S_FREE) && (pos_reg == idx_reg) && head;

    always_comb begin
        ring_ctrl.shift    = (state_reg == S_SCAN) || (state_reg == S_MARK)
                          || (state_reg == S_FREE);
        ring_ctrl.head_bit = head;
        if (state_reg == S_MARK && in_run) begin
            ring_ctrl.head_bit = 1'b1;
        end else if (state_reg == S_FREE && pos_reg == idx_reg) begin
            ring_ctrl.head_bit = 1'b0;
        end
    end

    bffa_chain u_chain (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ring_ctrl),
        .head_out (head)
    );

    // ---- counters as they stand after the request ----
    always_comb begin
        used_next   = used_reg;
        live_next   = live_reg;
        allocs_next = allocs_reg;
        frees_next  = frees_reg;
        case (status_reg)
            STS_ALLOC: begin
                used_next   = used_reg + need_reg;
                live_next   = live_reg + 32'd1;
                allocs_next = allocs_reg + 32'd1;
            end
            STS_FREED: begin
                if (used_reg != '0) begin
                    used_next = used_reg - CNT_W'(1);
                end
                if (live_reg != 32'd0) begin
                    live_next = live_reg - 32'd1;
                end
                frees_next = frees_reg + 32'd1;
            end
            default: begin
            end
        endcase
    end

    logic [BYTES_W-1:0] used_bytes;
    logic               out_free;

    assign used_bytes = BYTES_W'(used_next) << BLOCK_SHIFT;
    assign out_free   = !m_valid_reg || m_ready;

    // ---- sequencer ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            base_addr_reg <= 32'h0020_0000;
            pos_reg       <= '0;
            run_reg       <= '0;
            found_reg     <= 1'b0;
            freed_reg     <= 1'b0;
            status_reg    <= STS_FAIL;
            used_reg      <= '0;
            live_reg      <= '0;
            allocs_reg    <= '0;
            frees_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                base_addr_reg <= cfg_data;
            end
            // a beat taken in the commit cycle is replaced there
            if (m_valid_reg && m_ready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        pos_reg   <= '0;
                        run_reg   <= '0;
                        found_reg <= 1'b0;
                        freed_reg <= 1'b0;
                        if (s_data.kind == KIND_FREE) begin
                            idx_reg <= offset[BLOCK_SHIFT +: BLK_W];
                            if (free_reject) begin
                                status_reg <= STS_IGNORED;
                                state_reg  <= S_DONE;
                            end else begin
                                state_reg  <= S_FREE;
                            end
                        end else begin
                            need_reg <= need_full[CNT_W-1:0];
                            if (alloc_reject) begin
                                status_reg <= STS_FAIL;
                                state_reg  <= S_DONE;
                            end else begin
                                state_reg  <= S_SCAN;
                            end
                        end
                    end
                end
                S_SCAN: begin
                    pos_reg <= last ? '0 : pos_reg + BLK_W'(1);
                    if (!found_reg) begin
                        run_reg <= head ? '0 : run_inc;
                    end
                    if (hit) begin
                        found_reg <= 1'b1;
                        start_reg <= start_full[BLK_W-1:0];
                        end_reg   <= pos_ext + CNT_W'(1);
                    end
                    if (last) begin
                        if (found_reg || hit) begin
                            state_reg <= S_MARK;
                        end else begin
                            status_reg <= STS_FAIL;
                            state_reg  <= S_DONE;
                        end
                    end
                end
                S_MARK: begin
                    pos_reg <= last ? '0 : pos_reg + BLK_W'(1);
                    if (last) begin
                        status_reg <= STS_ALLOC;
                        state_reg  <= S_DONE;
                    end
                end
                S_FREE: begin
                    pos_reg <= last ? '0 : pos_reg + BLK_W'(1);
                    if (free_hit) begin
                        freed_reg <= 1'b1;
                    end
                    if (last) begin
                        status_reg <= (freed_reg || free_hit) ? STS_FREED : STS_IGNORED;
                        state_reg  <= S_DONE;
                    end
                end
                S_DONE: begin
                    // wait for the result register, then commit counters
                    if (out_free) begin
                        used_reg    <= used_next;
                        live_reg    <= live_next;
                        allocs_reg  <= allocs_next;
                        frees_reg   <= frees_next;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // result payload, loaded in the commit cycle
    always_ff @(posedge aclk) begin
        if (state_reg == S_DONE && out_free) begin
            m_data_reg.status        <= status_reg;
            m_data_reg.alloc_address <= (status_reg == STS_ALLOC)
                ? base_addr_reg + (32'(start_reg) << BLOCK_SHIFT) : 32'd0;
            m_data_reg.used_bytes    <= used_bytes;
            m_data_reg.free_bytes    <= BYTES_W'(HEAP_BYTES) - used_bytes;
            m_data_reg.used_blocks   <= USED_W'(used_next);
            m_data_reg.live_allocs   <= live_next;
            m_data_reg.allocs_total  <= allocs_next;
            m_data_reg.frees_total   <= frees_next;
        end
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

endmodule
`default_nettype wire

// ----- hdl/bffa_checker.sv -----
`default_nettype none
`include "bitmap_first_fit_block_allocator_unit_assert.svh"
module bffa_checker
    import bffa_pkg::*;
(
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire rsp_t m_data
);

    `BFFA_ASSERT_NEXT(a_one_in_flight, s_valid && s_ready, !s_ready, "request accepted while busy")
    `BFFA_ASSERT_IMPL(a_addr_zero, m_valid && m_data.status != STS_ALLOC, m_data.alloc_address == 32'd0, "address set on a result that did not allocate")
    `BFFA_ASSERT_IMPL(a_bytes_sum, m_valid, BYTES_W'(m_data.used_bytes + m_data.free_bytes) == BYTES_W'(HEAP_BYTES), "used and free bytes do not cover the heap")
    `BFFA_ASSERT_IMPL(a_bytes_blocks, m_valid, m_data.used_bytes == (BYTES_W'(m_data.used_blocks) << BLOCK_SHIFT), "used bytes disagree with used blocks")
    `BFFA_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_data), "stalled result beat changed")

endmodule

bind bitmap_first_fit_block_allocator_unit bffa_checker u_bffa_checker (.*);
`default_nettype wire
